FILE: design/tkc_pkg.sv
// Shared types and constants for the top-k count tracker.
package tkc_pkg;

  // Fixed field widths
  localparam int CMD_W      = 2;
  localparam int KEY_W      = 16;
  localparam int IN_CNT_W   = 16;
  localparam int RANK_W     = 6;
  localparam int MIN_W      = 16;
  localparam int OUT_CNT_W  = 16;

  // Stream packing
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  // Read select tree: groups of eight cells
  localparam int GRP_SZ    = 8;
  localparam int GRP_IDX_W = 3;
  localparam int GRP_HI_W  = RANK_W - GRP_IDX_W;

  // Reset value of the minimum count register
  localparam logic [MIN_W-1:0] MIN_COUNT_RST = 16'd1;

  // Command codes carried in tuser
  localparam logic [CMD_W-1:0] CMD_OFFER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic offer_en;  // insert the offered pair this cycle
    logic clear_en;  // empty the list
    logic read_en;   // load the first select stage
    logic sel_en;    // load the result register
  } ctrl_cmd_t;

endpackage

FILE: design/top_k_count_tracker.sv
// Top level of the top-k count tracker: stream ports, controller and datapath.
//
// Keeps a descending list of up to ENTRIES (key, count) pairs in register cells.
// Input stream: in_tuser carries the command (offer, read, clear), in_tdata the
// key, the count and the rank to read. Output stream: one result per read,
// out_tdata holds key and count, out_tuser the entry-valid flag.
// An offer or a clear takes effect at its accept edge; back-to-back offers run
// at one per cycle while no read is pending, since every cell compares against
// the offered count and shifts in parallel.
// A read goes through a two-stage select tree (groups of eight cells, then the
// group): out_tvalid rises once the controller has gone from ST_RSEL to ST_OUT,
// and in_tready stays low from the read until its result is taken.
// While the receiver stalls, the result holds and no request is taken.
// Reset (rst_n low, synchronous) empties the list and sets min_count to 1;
// cell contents are not cleared. cfg_wr_en writes min_count.
module top_k_count_tracker
  import tkc_pkg::*;
#(
  parameter int ENTRIES     = 64,
  parameter int COUNT_WIDTH = 16
)(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: key_id[15:0], item_count[31:16], rank_index[37:32], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: command[1:0]
  input  logic [CMD_W-1:0]       in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_tdata: entry_key[15:0], entry_count[31:16]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: entry_valid[0]
  output logic                   out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_wr_en,
  input  logic [MIN_W-1:0]       cfg_wr_data
);

  ctrl_cmd_t             cmd;
  logic [KEY_W-1:0]      entry_key;
  logic [OUT_CNT_W-1:0]  entry_count;

  tkc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  tkc_datapath #(
    .ENTRIES     (ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .key_id      (in_tdata[15:0]),
    .item_count  (in_tdata[31:16]),
    .rank_index  (in_tdata[37:32]),
    .entry_key   (entry_key),
    .entry_count (entry_count),
    .entry_valid (out_tuser)
  );

  assign out_tdata = {entry_count, entry_key};

endmodule

FILE: design/tkc_ctrl.sv
// Controller state machine: handshakes and command sequencing.
module tkc_ctrl
  import tkc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output ctrl_cmd_t        cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RSEL = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign in_acc     = in_tvalid && in_tready;

  // Decode the accepted request into datapath commands
  always_comb begin
    cmd.offer_en = in_acc && (in_cmd == CMD_OFFER);
    cmd.clear_en = in_acc && (in_cmd == CMD_CLEAR);
    cmd.read_en  = in_acc && (in_cmd == CMD_READ);
    cmd.sel_en   = (state_r == ST_RSEL);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.read_en) state_nxt = ST_RSEL;
      end
      ST_RSEL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/tkc_datapath.sv
// Datapath: ranked register cells, parallel insert, two-stage read select.
module tkc_datapath
  import tkc_pkg::*;
#(
  parameter int ENTRIES     = 64,
  parameter int COUNT_WIDTH = 16
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  input  logic                 cfg_wr_en,
  input  logic [MIN_W-1:0]     cfg_wr_data,
  input  logic [KEY_W-1:0]     key_id,
  input  logic [IN_CNT_W-1:0]  item_count,
  input  logic [RANK_W-1:0]    rank_index,
  output logic [KEY_W-1:0]     entry_key,
  output logic [OUT_CNT_W-1:0] entry_count,
  output logic                 entry_valid
);

  localparam int FW   = $clog2(ENTRIES + 1);
  localparam int NGRP = (ENTRIES + GRP_SZ - 1) / GRP_SZ;
  localparam logic [31:0] CNT_MASK =
    (COUNT_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << COUNT_WIDTH) - 32'd1);

  // List cells and control
  logic [KEY_W-1:0]       key_r [ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_r [ENTRIES];
  logic [FW-1:0]          fill_r;
  logic [MIN_W-1:0]       min_r;

  // Read select stages
  logic [KEY_W-1:0]       grp_key_r   [NGRP];
  logic [COUNT_WIDTH-1:0] grp_cnt_r   [NGRP];
  logic [KEY_W-1:0]       grp_key_nxt [NGRP];
  logic [COUNT_WIDTH-1:0] grp_cnt_nxt [NGRP];
  logic [GRP_HI_W-1:0]    rank_hi_r;
  logic                   rd_valid_r;
  logic [KEY_W-1:0]       out_key_r;
  logic [COUNT_WIDTH-1:0] out_cnt_r;
  logic                   out_valid_r;
  logic [KEY_W-1:0]       out_key_nxt;
  logic [COUNT_WIDTH-1:0] out_cnt_nxt;

  // Offer evaluation
  logic [31:0]            cnt_wide;
  logic [31:0]            min_wide;
  logic [COUNT_WIDTH-1:0] cnt_c;
  logic                   full;
  logic                   take;
  logic [ENTRIES-1:0]     after;
  logic                   do_ins;

  assign cnt_wide = 32'(item_count) & CNT_MASK;
  assign min_wide = 32'(min_r) & CNT_MASK;
  assign cnt_c    = cnt_wide[COUNT_WIDTH-1:0];
  assign full     = (fill_r == FW'(ENTRIES));
  assign take     = (cnt_wide > min_wide) && !(full && (cnt_c <= cnt_r[ENTRIES-1]));
  assign do_ins   = cmd.offer_en && take;

  // Cells at or past the insert point: smaller count, or empty
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      after[i] = (cnt_r[i] < cnt_c) || (FW'(i) >= fill_r);
    end
  end

  // Each cell keeps, takes the new pair, or shifts from the cell above
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_ins && after[0]) begin
          key_r[0] <= key_id;
          cnt_r[0] <= cnt_c;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (do_ins && after[i]) begin
          if (!after[i-1]) begin
            key_r[i] <= key_id;
            cnt_r[i] <= cnt_c;
          end else begin
            key_r[i] <= key_r[i-1];
            cnt_r[i] <= cnt_r[i-1];
          end
        end
      end
    end
  end

  // Fill level and minimum count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      min_r  <= MIN_COUNT_RST;
    end else begin
      if (cfg_wr_en) min_r <= cfg_wr_data;
      if (cmd.clear_en) begin
        fill_r <= '0;
      end else if (do_ins && !full) begin
        fill_r <= fill_r + FW'(1);
      end
    end
  end

  // First select stage: one cell out of each group of eight
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_key_nxt[g] = '0;
      grp_cnt_nxt[g] = '0;
      for (int j = 0; j < GRP_SZ; j++) begin
        if ((g * GRP_SZ + j < ENTRIES) &&
            (rank_index[GRP_IDX_W-1:0] == GRP_IDX_W'(j))) begin
          grp_key_nxt[g] = key_r[g * GRP_SZ + j];
          grp_cnt_nxt[g] = cnt_r[g * GRP_SZ + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_key_r[g] <= grp_key_nxt[g];
        grp_cnt_r[g] <= grp_cnt_nxt[g];
      end
      rank_hi_r  <= rank_index[RANK_W-1:GRP_IDX_W];
      rd_valid_r <= (8'(rank_index) < 8'(fill_r));
    end
  end

  // Second select stage: pick the group, zero an empty rank
  always_comb begin
    out_key_nxt = '0;
    out_cnt_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (rd_valid_r && (rank_hi_r == GRP_HI_W'(g))) begin
        out_key_nxt = grp_key_r[g];
        out_cnt_nxt = grp_cnt_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_en) begin
      out_key_r   <= out_key_nxt;
      out_cnt_r   <= out_cnt_nxt;
      out_valid_r <= rd_valid_r;
    end
  end

  assign entry_key   = out_key_r;
  assign entry_count = OUT_CNT_W'(32'(out_cnt_r));
  assign entry_valid = out_valid_r;

endmodule

FILE: design/tkc_checker.sv
// Port-level checks for the top-k count tracker, bound to the top level.
module tkc_checker
  import tkc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic [CMD_W-1:0]       in_tuser,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  // A stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // An empty rank reads as zero key and count
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata == '0))
    else $error("empty rank returned nonzero data");

  // An accepted read request is followed by a valid result, with no wait on out_tready
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_READ) |-> ##2 out_tvalid)
    else $error("read result late");

  // No request is taken while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while result pending");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind top_k_count_tracker tkc_checker u_tkc_checker (.*);

FILE: tb/sv/top_k_count_tracker_checker.sv
// Checker for the top-k count tracker: predicts read results and compares them.
`timescale 1ns / 100ps

module top_k_count_tracker_checker
  import tkc_pkg::*;
#(
  parameter int ENTRIES = 64
)(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: key_id[15:0], item_count[31:16], rank_index[37:32], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: command[1:0]
  input  logic [CMD_W-1:0]       in_tuser,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // out_tdata: entry_key[15:0], entry_count[31:16]
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: entry_valid[0]
  input  logic                   out_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_wr_en,
  input  logic [MIN_W-1:0]       cfg_wr_data,
  output int                     mismatches,
  output int                     outstanding
);

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [OUT_CNT_W-1:0] count;
    logic                 valid;
  } rank_entry_t;

  // Predicted list, highest count at rank 0
  logic [KEY_W-1:0]    held_keys   [ENTRIES];
  logic [IN_CNT_W-1:0] held_counts [ENTRIES];
  int                  held_fill;
  logic [MIN_W-1:0]    count_floor;

  rank_entry_t pending_entries[$];
  rank_entry_t want;
  rank_entry_t got;
  int          fail_total = 0;

  // Insert before the first strictly smaller count; ties keep arrival order
  function automatic void place_offer(input logic [KEY_W-1:0] key,
                                      input logic [IN_CNT_W-1:0] cnt);
    int pos;
    int last;
    if (cnt <= count_floor) return;
    if (held_fill == ENTRIES && cnt <= held_counts[ENTRIES-1]) return;
    pos = held_fill;
    for (int i = 0; i < held_fill; i++) begin
      if (held_counts[i] < cnt) begin
        pos = i;
        break;
      end
    end
    last = (held_fill < ENTRIES) ? held_fill : ENTRIES - 1;
    for (int i = last; i > pos; i--) begin
      held_keys[i]   = held_keys[i-1];
      held_counts[i] = held_counts[i-1];
    end
    if (pos < ENTRIES) begin
      held_keys[pos]   = key;
      held_counts[pos] = cnt;
    end
    if (held_fill < ENTRIES) held_fill++;
  endfunction

  // Entry at a rank; empty ranks read as all zero
  function automatic rank_entry_t rank_lookup(input logic [RANK_W-1:0] rank);
    rank_entry_t e;
    e = '0;
    if (int'(rank) < held_fill && int'(rank) < ENTRIES) begin
      e.key   = held_keys[rank];
      e.count = held_counts[rank];
      e.valid = 1'b1;
    end
    return e;
  endfunction

  // Track requests and configuration, compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      held_fill   = 0;
      count_floor = MIN_COUNT_RST;
      pending_entries.delete();
    end else begin
      if (cfg_wr_en) count_floor = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          CMD_OFFER: place_offer(in_tdata[KEY_W-1:0], in_tdata[KEY_W +: IN_CNT_W]);
          CMD_READ: begin
            pending_entries = {pending_entries,
                               rank_lookup(in_tdata[KEY_W+IN_CNT_W +: RANK_W])};
          end
          CMD_CLEAR: held_fill = 0;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.key   = out_tdata[KEY_W-1:0];
        got.count = out_tdata[KEY_W +: OUT_CNT_W];
        got.valid = out_tuser;
        if (pending_entries.size() == 0) begin
          $error("unexpected result: key %h count %h valid %b", got.key, got.count, got.valid);
          fail_total++;
        end else begin
          want = pending_entries.pop_front();
          if (got.key !== want.key) begin
            $error("entry_key: expected %h, got %h", want.key, got.key);
            fail_total++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %h, got %h", want.count, got.count);
            fail_total++;
          end
          if (got.valid !== want.valid) begin
            $error("entry_valid: expected %b, got %b", want.valid, got.valid);
            fail_total++;
          end
        end
      end
    end
    outstanding <= pending_entries.size();
    mismatches  <= fail_total;
  end

endmodule

FILE: tb/sv/top_k_count_tracker_tb.sv
// Testbench top for the top-k count tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module top_k_count_tracker_tb;
  import tkc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SEG_ITEMS = 78;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = CMD_OFFER;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [MIN_W-1:0]       cfg_wr_data = '0;

  int mismatches;
  int outstanding;
  int tx_idle_pct = 38;
  int rx_idle_pct = 61;

  // Minimum count used in each segment; negative picks a small random value
  int floor_plan [12] = '{0, 65535, 3, -1, 1, 20, 0, -1, 7, 65535, 0, 2};

  top_k_count_tracker uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  top_k_count_tracker_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Send one request, with random idle cycles ahead of it
  task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                          input logic [IN_CNT_W-1:0] cnt, input logic [RANK_W-1:0] rank);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W-KEY_W-IN_CNT_W-RANK_W){1'b0}}, rank, cnt, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and let every pending read come back
  task automatic drain();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_min(input logic [MIN_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly offers and reads; narrow counts make ties and full-list rejects common
  task automatic random_req(input logic narrow);
    int                  roll;
    logic [CMD_W-1:0]    cmd;
    logic [IN_CNT_W-1:0] cnt;
    logic [RANK_W-1:0]   rank;
    roll = $urandom_range(99);
    if (roll < 62) cmd = CMD_OFFER;
    else if (roll < 94) cmd = CMD_READ;
    else if (roll < 96) cmd = CMD_CLEAR;
    else cmd = CMD_UNUSED;
    if (narrow || $urandom_range(9) < 7) cnt = IN_CNT_W'($urandom_range(24));
    else cnt = IN_CNT_W'($urandom);
    if ($urandom_range(1)) rank = RANK_W'($urandom_range(15));
    else rank = RANK_W'($urandom_range(63));
    push_req(cmd, KEY_W'($urandom), cnt, rank);
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int floor_val;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty reads, counts at and below the minimum, ties, extremes
    push_req(CMD_READ,   16'h0000, 16'h0000, 6'd0);
    push_req(CMD_OFFER,  16'hFFFF, 16'h0000, 6'd0);
    push_req(CMD_OFFER,  16'h1234, 16'h0001, 6'd0);
    push_req(CMD_OFFER,  16'hFFFF, 16'h0002, 6'd0);
    push_req(CMD_OFFER,  16'h0000, 16'hFFFF, 6'd0);
    push_req(CMD_OFFER,  16'h00AA, 16'h0002, 6'd63);
    push_req(CMD_OFFER,  16'h5555, 16'h8000, 6'd0);
    push_req(CMD_UNUSED, 16'hABCD, 16'h9999, 6'd0);
    push_req(CMD_READ,   16'hFFFF, 16'hFFFF, 6'd0);
    push_req(CMD_READ,   16'h0000, 16'h0000, 6'd1);
    push_req(CMD_READ,   16'h0000, 16'h0000, 6'd2);
    push_req(CMD_READ,   16'h0000, 16'h0000, 6'd3);
    push_req(CMD_READ,   16'h0000, 16'h0000, 6'd4);
    push_req(CMD_READ,   16'h0000, 16'h0000, 6'd63);
    push_req(CMD_CLEAR,  16'hFFFF, 16'hFFFF, 6'd63);
    push_req(CMD_READ,   16'h0000, 16'h0000, 6'd0);
    push_req(CMD_OFFER,  16'hAAAA, 16'h0007, 6'd63);
    push_req(CMD_READ,   16'h0000, 16'h0000, 6'd0);
    push_req(CMD_READ,   16'h0000, 16'h0000, 6'd1);

    // Random: three idle profiles, each over four minimum-count settings
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 38;
          rx_idle_pct = 61;
        end
        1: begin
          tx_idle_pct = 61;
          rx_idle_pct = 38;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        drain();
        floor_val = floor_plan[phase*4 + seg];
        if (floor_val < 0) floor_val = $urandom_range(40);
        write_min(floor_val[MIN_W-1:0]);
        if ($urandom_range(1)) begin
          push_req(CMD_CLEAR, KEY_W'($urandom), IN_CNT_W'($urandom), RANK_W'($urandom));
        end
        repeat (SEG_ITEMS) random_req(seg[0]);
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tkc_pkg.sv
design/tkc_ctrl.sv
design/tkc_datapath.sv
design/top_k_count_tracker.sv
design/tkc_checker.sv
tb/sv/top_k_count_tracker_checker.sv
tb/sv/top_k_count_tracker_tb.sv
